// ===== rtl/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  // Position within a three-byte group
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // Pad character '='
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // Symbol counts of a job, stored as index of the last symbol
  localparam logic [1:0] LAST_ONE   = 2'd0;
  localparam logic [1:0] LAST_TWO   = 2'd1;
  localparam logic [1:0] LAST_THREE = 2'd2;
  localparam logic [1:0] LAST_FOUR  = 2'd3;

  // One encoded job: all characters caused by one input item
  typedef struct packed {
    logic [3:0][6:0] syms;      // characters, syms[0] goes out first
    logic [1:0]      last_idx;  // index of the last valid character
    logic            fin;       // item was the last byte of the message
  } job_t;

  // Queue status seen by the front end, the serializer and the checks
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] c;
    if (idx < 6'd26) begin
      c = 7'h41 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      c = 7'h61 + {1'b0, idx} - 7'd26;
    end else if (idx < 6'd62) begin
      c = 7'h30 + {1'b0, idx} - 7'd52;
    end else if (idx == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

// ===== rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Padded base64 encoder, one raw byte in, one ASCII character out per item.
// ----------------------------------------------------------------------------
// Bytes enter on the in_ stream with in_tlast marking the last byte of a
// message; characters leave on the out_ stream, out_tuser marking the last
// character caused by a byte and out_tlast the last character of the
// message. Each byte is turned into a job of one to four characters that
// waits in a queue of QUEUE_DEPTH jobs; the serializer sends one character
// per cycle while the output is ready. That output sets the pace: four
// characters per three bytes inside a message (one, one, two characters),
// and a final byte yields three or four when it carries '=' padding. Input
// stalls only when the queue is full.
// ----------------------------------------------------------------------------
module base64_stream_encoder import b64enc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] symbol, [7] zero
  output logic       out_tuser,  // run_end
  output logic       out_tlast   // message_end
);

  job_t       push_job;
  job_t       head_job;
  logic       push;
  logic       pop;
  q_status_t  q_status;
  logic [1:0] phase;
  logic [6:0] symbol;

  b64enc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_data   (in_tdata),
    .in_final  (in_tlast),
    .q_status  (q_status),
    .push      (push),
    .job       (push_job),
    .phase     (phase)
  );

  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  b64enc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_job    (head_job),
    .q_status    (q_status),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_symbol  (symbol),
    .out_run_end (out_tuser),
    .out_msg_end (out_tlast)
  );

  assign out_tdata = {1'b0, symbol};

  // Checks
  a_msg_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("message end without run end");

  a_final_restarts_group: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> phase == PH_FIRST)
    else $error("group phase not cleared after final byte");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty) && (in_tready == !q_status.full))
    else $error("queue status inconsistent");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

// ===== rtl/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts raw bytes, tracks the group phase and leftover bits, and builds
// one job holding every character the byte causes.
// ----------------------------------------------------------------------------
module b64enc_front import b64enc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_data,
  input  logic       in_final,
  input  q_status_t  q_status,
  output logic       push,
  output job_t       job,
  output logic [1:0] phase
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && in_tready;
  assign phase     = phase_r;

  // Build the job and the next group state
  always_comb begin
    job.syms  = {PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR};
    job.fin   = in_final;
    unique case (phase_r)
      PH_SECOND: begin
        job.syms[0]  = b64_char({carry_r[1:0], in_data[7:4]});
        job.syms[1]  = b64_char({in_data[3:0], 2'b00});
        job.last_idx = in_final ? LAST_THREE : LAST_ONE;
        phase_nxt    = PH_THIRD;
        carry_nxt    = in_data[3:0];
      end
      PH_THIRD: begin
        job.syms[0]  = b64_char({carry_r[3:0], in_data[7:6]});
        job.syms[1]  = b64_char(in_data[5:0]);
        job.last_idx = LAST_TWO;
        phase_nxt    = PH_FIRST;
        carry_nxt    = 4'd0;
      end
      // first byte of a group; the unused code behaves the same
      default: begin
        job.syms[0]  = b64_char(in_data[7:2]);
        job.syms[1]  = b64_char({in_data[1:0], 4'b0000});
        job.last_idx = in_final ? LAST_FOUR : LAST_ONE;
        phase_nxt    = PH_SECOND;
        carry_nxt    = {2'b00, in_data[1:0]};
      end
    endcase
    // a message end restarts the group
    if (in_final) begin
      phase_nxt = PH_FIRST;
      carry_nxt = 4'd0;
    end
  end

  // Group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      carry_r <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

// ===== rtl/b64enc_queue.sv =====
// ----------------------------------------------------------------------------
// b64enc_queue
// Short job queue between the front end and the serializer.
// ----------------------------------------------------------------------------
module b64enc_queue import b64enc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;

  assign head_job     = slots_r[rptr_r];
  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// Walks the head job one character per unstalled cycle to the output register.
// ----------------------------------------------------------------------------
module b64enc_back import b64enc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head_job,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [6:0] out_symbol,
  output logic       out_run_end,
  output logic       out_msg_end
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [6:0] sym_r;
  logic       run_end_r;
  logic       msg_end_r;
  logic       load;
  logic       is_last;

  assign load       = !q_status.empty && (!valid_r || out_tready);
  assign is_last    = (idx_r == head_job.last_idx);
  assign pop        = load && is_last;
  assign out_tvalid = valid_r;
  assign out_symbol = sym_r;
  assign out_run_end = run_end_r;
  assign out_msg_end = msg_end_r;

  // Character index within the head job, and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      sym_r     <= head_job.syms[idx_r];
      run_end_r <= is_last;
      msg_end_r <= is_last && head_job.fin;
    end
  end

endmodule

// ===== test/base64_stream_encoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_test
// Self-checking bench for the padded base64 stream encoder. A driver feeds
// raw bytes grouped into messages from a queue; a scoreboard encodes every
// accepted byte on its own and compares each character that leaves the block,
// including the run and message end flags. Runs directed corner messages, then
// random messages under several sender/receiver idle mixes and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module base64_stream_encoder_test;
  import b64enc_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 20;
  // Alphabet in index order, index 0 in the top byte
  localparam logic [8*64-1:0] LETTERS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } src_byte_t;

  typedef struct packed {
    logic [6:0] symbol;
    logic       run_end;
    logic       message_end;
  } b64_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  // Bytes waiting to be offered, characters waiting to come out
  src_byte_t pending_bytes[$];
  b64_char_t expected_chars[$];
  src_byte_t next_byte;

  // Encoder state as seen by the scoreboard
  logic [1:0] enc_phase = PH_FIRST;
  logic [3:0] enc_carry = 4'h0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_toggle    = 1'b0;
  bit  hold_seen      = 1'b0;
  int  hold_left      = 0;
  logic in_taken      = 1'b0;
  int  idle_cycles    = 0;
  int  mismatches     = 0;
  int  bytes_in       = 0;
  int  chars_out      = 0;
  int  messages_out   = 0;
  int  bytes_queued   = 0;

  base64_stream_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic logic [6:0] alphabet_symbol(input logic [5:0] idx);
    return LETTERS[8*(63 - idx) +: 7];
  endfunction

  // Encode one accepted byte and queue the characters it must produce
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [6:0] syms [0:3];
    int         n;
    b64_char_t  c;
    n = 1;
    case (enc_phase)
      PH_SECOND: begin
        syms[0] = alphabet_symbol({enc_carry[1:0], b[7:4]});
        if (fin) begin
          syms[1] = alphabet_symbol({b[3:0], 2'b00});
          syms[2] = PAD_CHAR;
          n = 3;
        end
        enc_phase = PH_THIRD;
        enc_carry = b[3:0];
      end
      PH_THIRD: begin
        syms[0] = alphabet_symbol({enc_carry, b[7:6]});
        syms[1] = alphabet_symbol(b[5:0]);
        n = 2;
        enc_phase = PH_FIRST;
        enc_carry = 4'h0;
      end
      default: begin
        // the unused fourth phase behaves as a group start
        syms[0] = alphabet_symbol(b[7:2]);
        if (fin) begin
          syms[1] = alphabet_symbol({b[1:0], 4'b0000});
          syms[2] = PAD_CHAR;
          syms[3] = PAD_CHAR;
          n = 4;
        end
        enc_phase = PH_SECOND;
        enc_carry = {2'b00, b[1:0]};
      end
    endcase
    for (int k = 0; k < n; k++) begin
      c.symbol      = syms[k];
      c.run_end     = (k == n - 1);
      c.message_end = fin && (k == n - 1);
      expected_chars.push_back(c);
    end
    // a final byte starts the next message from scratch
    if (fin) begin
      enc_phase = PH_FIRST;
      enc_carry = 4'h0;
    end
  endtask

  // Accept side: scoreboard update and output check
  always @(posedge clk) begin
    b64_char_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        encode_byte(in_tdata, in_tlast);
        bytes_in++;
      end
      if (out_tvalid && out_tready) begin
        chars_out++;
        if (out_tlast) messages_out++;
        if (expected_chars.size() == 0) begin
          $error("unexpected item: tdata %h tuser %b tlast %b",
                 out_tdata, out_tuser, out_tlast);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata[6:0] !== want.symbol) begin
            $error("symbol: expected %h, got %h", want.symbol, out_tdata[6:0]);
            mismatches++;
          end
          if (out_tdata[7] !== 1'b0) begin
            $error("tdata[7]: expected 0, got %b", out_tdata[7]);
            mismatches++;
          end
          if (out_tuser !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, out_tuser);
            mismatches++;
          end
          if (out_tlast !== want.message_end) begin
            $error("message_end: expected %b, got %b", want.message_end, out_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  // Byte driver: holds an item until taken, idles at random between items
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_byte.data;
        in_tlast  <= next_byte.fin;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Character sink: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: no traffic for too long while work is outstanding
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (pending_bytes.size() == 0 && expected_chars.size() == 0 && !in_tvalid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("base64_stream_encoder_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic fin);
    src_byte_t s;
    s.data = data;
    s.fin  = fin;
    pending_bytes.push_back(s);
    bytes_queued++;
  endtask

  // Random message: mostly short, now and then a long one, corner bytes mixed in
  task automatic push_message();
    int len;
    logic [7:0] d;
    len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = $urandom_range(255);
      endcase
      push_byte(d, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_tvalid || expected_chars.size() != 0)
      @(posedge clk);
  endtask

  task automatic random_phase(input int n_bytes, input int send_idle,
                              input int recv_stall);
    int start;
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) push_message();
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one-byte messages at the extremes
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // final byte in the second and third position of a group
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
    // all '+' and all '/' quartets
    push_byte(8'hFB, 1'b0); push_byte(8'hEF, 1'b0); push_byte(8'hBE, 1'b1);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
    // full group then a padded tail
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h80, 1'b0); push_byte(8'h7F, 1'b0); push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0); push_byte(8'h0F, 1'b1);
    wait_drained();

    // Random traffic under each idle mix
    random_phase(76, 0, 0);
    random_phase(76, 71, 0);
    random_phase(76, 0, 71);
    random_phase(76, 10, 10);

    // Long receiver hold-off with the sender pushing flat out
    hold_toggle = ~hold_toggle;
    random_phase(30, 0, 0);

    repeat (SETTLE) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d characters never arrived", expected_chars.size());
      mismatches++;
    end
    $display("Encoded %0d bytes into %0d characters over %0d messages,",
             bytes_in, chars_out, messages_out);
    $display("with directed corners, four idle mixes and a long output hold-off.");
    if (mismatches == 0) begin
      $display("base64_stream_encoder_test passed");
    end else begin
      $display("base64_stream_encoder_test failed");
    end
    $finish;
  end

endmodule
